### rtl/serial_receive_with_timeouts_defines.svh
// Assertion helpers used by the receive controller core (srt_core).
// They expand to nothing when SYNTH is defined.
`ifndef SERIAL_RECEIVE_WITH_TIMEOUTS_DEFINES_SVH
`define SERIAL_RECEIVE_WITH_TIMEOUTS_DEFINES_SVH

`ifndef SYNTH
`define SRT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SRT_ASSERT(lbl, clk, rst_n, prop, msg)
`define SRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/srt_pkg.sv
package srt_pkg;

    localparam int REQ_W     = 2;
    localparam int COUNT_W   = 12;
    localparam int TIMEOUT_W = 15;
    localparam int BYTE_W    = 8;
    localparam int TICKS_W   = 10;

    localparam logic [REQ_W-1:0] REQ_START = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_BYTE  = 2'd2;

    localparam logic [COUNT_W-1:0] MAX_LEN     = 12'd4095;
    localparam logic [BYTE_W-1:0]  INTER_RESET = 8'd4;
    localparam logic [TICKS_W-1:0] ELAPSED_MAX = 10'd1023;

    // ms * 182 / 10000 is computed as (ms * TICK_RECIP) >> TICK_SHIFT, where
    // TICK_RECIP = ceil(91 * 2^28 / 5000). This is exact for every 15-bit ms.
    localparam int RECIP_W    = 23;
    localparam int PROD_W     = TIMEOUT_W + RECIP_W;
    localparam int TICK_SHIFT = 28;
    localparam logic [RECIP_W-1:0] TICK_RECIP = 23'd4885526;
    localparam logic [TICKS_W-1:0] TICK_ADD   = 10'd1;

    typedef struct packed {
        logic [REQ_W-1:0]     req_type;
        logic [COUNT_W-1:0]   wanted_count;
        logic [TIMEOUT_W-1:0] window_ms;
        logic [BYTE_W-1:0]    rx_byte;
    } t_req;

    typedef struct packed {
        logic                 data_valid;
        logic [BYTE_W-1:0]    data_byte;
        logic [COUNT_W-1:0]   byte_index;
        logic                 done_res;
        logic                 timed_out;
        logic [COUNT_W-1:0]   received_count;
    } t_res;

endpackage

### rtl/srt_req_if.sv
interface srt_req_if;
    import srt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [REQ_W-1:0]     req_type;
    logic [COUNT_W-1:0]   wanted_count;
    logic [TIMEOUT_W-1:0] window_ms;
    logic [BYTE_W-1:0]    rx_byte;

    modport source (
        output valid, req_type, wanted_count, window_ms, rx_byte,
        input  ready
    );

    modport sink (
        input  valid, req_type, wanted_count, window_ms, rx_byte,
        output ready
    );
endinterface

### rtl/srt_res_if.sv
interface srt_res_if;
    import srt_pkg::*;

    logic               valid;
    logic               ready;
    logic               data_valid;
    logic [BYTE_W-1:0]  data_byte;
    logic [COUNT_W-1:0] byte_index;
    logic               done_res;
    logic               timed_out;
    logic [COUNT_W-1:0] received_count;

    modport source (
        output valid, data_valid, data_byte, byte_index, done_res, timed_out,
               received_count,
        input  ready
    );

    modport sink (
        input  valid, data_valid, data_byte, byte_index, done_res, timed_out,
               received_count,
        output ready
    );
endinterface

### rtl/srt_limit_calc.sv
module srt_limit_calc (
    input  logic [srt_pkg::TIMEOUT_W-1:0] i_window_ms,
    output logic [srt_pkg::TICKS_W-1:0]   o_first_limit
);
    import srt_pkg::*;

    logic [PROD_W-1:0]  product;
    logic [TICKS_W-1:0] quotient;

    assign product       = PROD_W'(i_window_ms) * PROD_W'(TICK_RECIP);
    assign quotient      = product[TICK_SHIFT +: TICKS_W];
    assign o_first_limit = quotient + TICK_ADD;
endmodule

### rtl/srt_core.sv
`include "serial_receive_with_timeouts_defines.svh"

module srt_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  srt_pkg::t_req               i_item,
    input  logic [srt_pkg::BYTE_W-1:0]  i_inter_ticks,
    input  logic [srt_pkg::TICKS_W-1:0] i_first_limit,
    output logic                        o_res_valid,
    output srt_pkg::t_res               o_res
);
    import srt_pkg::*;

    logic               r_active,        n_active;
    logic [COUNT_W-1:0] r_target_count,  n_target_count;
    logic [COUNT_W-1:0] r_got_count,     n_got_count;
    logic [TICKS_W-1:0] r_first_limit,   n_first_limit;
    logic [TICKS_W-1:0] r_elapsed_ticks, n_elapsed_ticks;

    logic [COUNT_W-1:0] want_clamped;
    logic [TICKS_W-1:0] tick_limit;
    logic [TICKS_W-1:0] elapsed_inc;
    logic [COUNT_W-1:0] got_inc;

    assign want_clamped = (i_item.wanted_count > MAX_LEN) ? MAX_LEN : i_item.wanted_count;
    assign tick_limit   = (r_got_count == '0) ? r_first_limit : TICKS_W'(i_inter_ticks);
    assign elapsed_inc  = (r_elapsed_ticks < ELAPSED_MAX) ? r_elapsed_ticks + 10'd1
                                                          : r_elapsed_ticks;
    assign got_inc      = r_got_count + 12'd1;

    always_comb begin
        n_active        = r_active;
        n_target_count  = r_target_count;
        n_got_count     = r_got_count;
        n_first_limit   = r_first_limit;
        n_elapsed_ticks = r_elapsed_ticks;
        o_res_valid     = 1'b0;
        o_res           = '0;

        if (i_fire) begin
            if (i_item.req_type == REQ_START) begin
                n_got_count     = '0;
                n_elapsed_ticks = '0;
                n_target_count  = want_clamped;
                n_first_limit   = i_first_limit;
                if (want_clamped == '0) begin
                    // An empty read finishes on the spot.
                    n_active       = 1'b0;
                    o_res_valid    = 1'b1;
                    o_res.done_res = 1'b1;
                end else begin
                    n_active = 1'b1;
                end
            end else if (r_active && i_item.req_type == REQ_TICK) begin
                n_elapsed_ticks = elapsed_inc;
                if (elapsed_inc >= tick_limit) begin
                    n_active             = 1'b0;
                    o_res_valid          = 1'b1;
                    o_res.done_res       = 1'b1;
                    o_res.timed_out      = 1'b1;
                    o_res.received_count = r_got_count;
                end
            end else if (r_active && i_item.req_type == REQ_BYTE) begin
                n_got_count      = got_inc;
                n_elapsed_ticks  = '0;
                o_res_valid      = 1'b1;
                o_res.data_valid = 1'b1;
                o_res.data_byte  = i_item.rx_byte;
                o_res.byte_index = r_got_count;
                if (got_inc >= r_target_count) begin
                    n_active             = 1'b0;
                    o_res.done_res       = 1'b1;
                    o_res.received_count = got_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active        <= 1'b0;
            r_target_count  <= '0;
            r_got_count     <= '0;
            r_first_limit   <= '0;
            r_elapsed_ticks <= '0;
        end else begin
            r_active        <= n_active;
            r_target_count  <= n_target_count;
            r_got_count     <= n_got_count;
            r_first_limit   <= n_first_limit;
            r_elapsed_ticks <= n_elapsed_ticks;
        end
    end

    `SRT_ASSERT_NEXT(a_done_ends_read, i_clk, i_rst_n, o_res_valid && o_res.done_res, !r_active, "read still active after completion")
    `SRT_ASSERT_NEXT(a_byte_counts, i_clk, i_rst_n, i_fire && r_active && i_item.req_type == REQ_BYTE, r_got_count == $past(r_got_count) + 12'd1, "byte did not advance the count")
    `SRT_ASSERT(a_count_below_target, i_clk, i_rst_n, r_active |-> (r_got_count < r_target_count), "active read has reached its target")
endmodule

### rtl/serial_receive_with_timeouts.sv
// An accepted beat waits in the input register and, when it fires, its result is
// registered; beats that cause no result leave no trace on the output.
// Throughput: one beat per cycle, set by the input register and result register.
// While a result waits, the input register takes one more beat and then stalls.
// Reset (synchronous, active low) ends any read, empties both registers and sets
// the inter-byte tick limit to 4.
module serial_receive_with_timeouts (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [srt_pkg::BYTE_W-1:0] i_cfg_data,
    srt_req_if.sink                    i_req,
    srt_res_if.source                  o_res
);
    import srt_pkg::*;

    logic [BYTE_W-1:0] r_inter_ticks;
    logic              r_in_valid;
    t_req              r_in;
    logic              r_out_valid;
    t_res              r_out;

    logic               out_free;
    logic               fire;
    logic               in_accept;
    logic [TICKS_W-1:0] first_limit;
    logic               core_valid;
    t_res               core_res;

    assign out_free    = !r_out_valid || o_res.ready;
    assign fire        = r_in_valid && out_free;
    assign i_req.ready = !r_in_valid || out_free;
    assign in_accept   = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inter_ticks <= INTER_RESET;
        end else if (i_cfg_we) begin
            r_inter_ticks <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.req_type     <= i_req.req_type;
            r_in.wanted_count <= i_req.wanted_count;
            r_in.window_ms    <= i_req.window_ms;
            r_in.rx_byte      <= i_req.rx_byte;
        end
    end

    srt_limit_calc u_limit (
        .i_window_ms   (r_in.window_ms),
        .o_first_limit (first_limit)
    );

    srt_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_item        (r_in),
        .i_inter_ticks (r_inter_ticks),
        .i_first_limit (first_limit),
        .o_res_valid   (core_valid),
        .o_res         (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && core_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && core_valid) begin
            r_out <= core_res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.data_valid     = r_out.data_valid;
    assign o_res.data_byte      = r_out.data_byte;
    assign o_res.byte_index     = r_out.byte_index;
    assign o_res.done_res       = r_out.done_res;
    assign o_res.timed_out      = r_out.timed_out;
    assign o_res.received_count = r_out.received_count;
endmodule
